@@ rtl/bic_pkg.sv @@
// Shared types, offsets and a helper function for the banked interrupt controller.
package bic_pkg;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LINES = 2'd2;

    localparam logic [1:0] BANK_ZERO = 2'd0;
    localparam logic [1:0] BANK_ONE  = 2'd1;
    localparam logic [1:0] BANK_TWO  = 2'd2;

    localparam logic [5:0] OFF_PEND0 = 6'h00;
    localparam logic [5:0] OFF_PEND1 = 6'h04;
    localparam logic [5:0] OFF_PEND2 = 6'h08;
    localparam logic [5:0] OFF_EN0   = 6'h18;
    localparam logic [5:0] OFF_EN1   = 6'h10;
    localparam logic [5:0] OFF_EN2   = 6'h14;
    localparam logic [5:0] OFF_DIS0  = 6'h24;
    localparam logic [5:0] OFF_DIS1  = 6'h1c;
    localparam logic [5:0] OFF_DIS2  = 6'h20;

    // Bank-1 shortcut lines 7, 9, 10, 18, 19 and bank-2 lines 21 to 25 and 30.
    localparam logic [31:0] SC1_LINES = 32'h000c_0680;
    localparam logic [31:0] SC2_LINES = 32'h43e0_0000;

    localparam logic [6:0] IRQ_BASE1 = 7'd32;
    localparam logic [6:0] IRQ_BASE2 = 7'd64;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  offset;
        logic [31:0] write_data;
        logic [1:0]  line_bank;
        logic [31:0] line_levels;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [6:0]  active_irq;
        logic        irq_valid;
    } t_out;

    typedef struct packed {
        logic [7:0]  en0;
        logic [31:0] en1;
        logic [31:0] en2;
        logic [7:0]  raw0;
        logic [31:0] raw1;
        logic [31:0] raw2;
    } t_state;

    function automatic logic [4:0] lowest_bit(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/banked_interrupt_controller_core.sv @@
// Top level of the banked interrupt controller: input stage, state and result register.
//
//  Channel  Signals                                  Payload
//  input    i_in_valid / o_in_ready                  i_in_data  (bic_pkg::t_in)
//  output   o_out_valid / i_out_ready                o_out_data (bic_pkg::t_out)
//
// Each transfer passes through the input register and then the result register, and one
// item is taken per cycle while the output is not stalled.
// The state registers update when an item moves from the input register to the result
// register, and the result reflects the state after that update.
// Reset clears the enable masks, raw levels and both valid flags.
// An output stall holds the result and backs up the input register one item later.
module banked_interrupt_controller_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bic_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bic_pkg::t_out o_out_data
);
    import bic_pkg::*;

    logic   r_s1_valid;
    t_in    r_s1_item;
    logic   r_out_valid;
    t_out   r_out;
    logic   s1_adv;
    t_state next_state;
    t_out   result;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    bic_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (s1_adv),
        .i_item  (r_s1_item),
        .o_next  (next_state)
    );

    bic_prio u_prio (
        .i_item   (r_s1_item),
        .i_state  (next_state),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_data;
        end
        if (s1_adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/bic_regs.sv @@
// Enable masks and raw level registers with their write and update logic.
module bic_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_upd,
    input  bic_pkg::t_in    i_item,
    output bic_pkg::t_state o_next
);
    import bic_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_item.kind == KIND_WRITE) begin
            case (i_item.offset)
                OFF_EN0:  n_state.en0 = r_state.en0 | i_item.write_data[7:0];
                OFF_DIS0: n_state.en0 = r_state.en0 & ~i_item.write_data[7:0];
                OFF_EN1:  n_state.en1 = r_state.en1 | i_item.write_data;
                OFF_DIS1: n_state.en1 = r_state.en1 & ~i_item.write_data;
                OFF_EN2:  n_state.en2 = r_state.en2 | i_item.write_data;
                OFF_DIS2: n_state.en2 = r_state.en2 & ~i_item.write_data;
                default:  n_state = r_state;
            endcase
        end else if (i_item.kind == KIND_LINES) begin
            case (i_item.line_bank)
                BANK_ZERO: n_state.raw0 = i_item.line_levels[7:0];
                BANK_ONE:  n_state.raw1 = i_item.line_levels;
                BANK_TWO:  n_state.raw2 = i_item.line_levels;
                default:   n_state = r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_upd) begin
            r_state <= n_state;
        end
    end

    assign o_next = n_state;

endmodule

@@ rtl/bic_prio.sv @@
// Pending word assembly, bus read decode and active interrupt priority encoder.
module bic_prio (
    input  bic_pkg::t_in    i_item,
    input  bic_pkg::t_state i_state,
    output bic_pkg::t_out   o_result
);
    import bic_pkg::*;

    logic [7:0]  p0;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] stat;
    logic [31:0] sc1;
    logic [31:0] sc2;

    assign p0  = i_state.raw0 & i_state.en0;
    assign p1  = i_state.raw1 & i_state.en1;
    assign p2  = i_state.raw2 & i_state.en2;
    assign sc1 = p1 & SC1_LINES;
    assign sc2 = p2 & SC2_LINES;

    assign stat = {11'd0, p2[30], p2[25:21], p1[19:18], p1[10:9], p1[7],
                   |p2, |p1, p0};

    always_comb begin
        o_result.read_data = '0;
        if (i_item.kind == KIND_READ) begin
            case (i_item.offset)
                OFF_PEND0: o_result.read_data = stat;
                OFF_PEND1: o_result.read_data = p1;
                OFF_PEND2: o_result.read_data = p2;
                OFF_EN0:   o_result.read_data = {24'd0, i_state.en0};
                OFF_EN1:   o_result.read_data = i_state.en1;
                OFF_EN2:   o_result.read_data = i_state.en2;
                default:   o_result.read_data = '0;
            endcase
        end

        o_result.irq_valid  = |stat;
        o_result.active_irq = '0;
        if (|p0) begin
            o_result.active_irq = {2'd0, lowest_bit({24'd0, p0})};
        end else if (|sc1) begin
            o_result.active_irq = IRQ_BASE1 | {2'd0, lowest_bit(sc1)};
        end else if (|sc2) begin
            o_result.active_irq = IRQ_BASE2 | {2'd0, lowest_bit(sc2)};
        end else if (|p1) begin
            o_result.active_irq = IRQ_BASE1 | {2'd0, lowest_bit(p1)};
        end else if (|p2) begin
            o_result.active_irq = IRQ_BASE2 | {2'd0, lowest_bit(p2)};
        end
    end

endmodule

@@ rtl/bic_checker.sv @@
// Port-level assertions for the banked interrupt controller and their bind.
module bic_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input bic_pkg::t_out o_out_data
);
    import bic_pkg::*;

    a_idle_irq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.irq_valid) |-> (o_out_data.active_irq == 7'd0))
        else $error("active_irq is nonzero while irq_valid is low");

    a_irq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.active_irq[6:5] != 2'd3))
        else $error("active_irq beyond the last bank");

    a_bank0_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.active_irq[6:5] == 2'd0) |->
            (o_out_data.active_irq[4:3] == 2'd0))
        else $error("bank-0 active_irq beyond its eight lines");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result transfer changed or dropped");

endmodule

bind banked_interrupt_controller_core bic_checker u_bic_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
